[hw/rtl/sbfd_pkg.sv]
package sbfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int ID_W      = 16;
	localparam int PAYLOAD_W = 64;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;

	// Sync byte values after reset
	localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'h55;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h0E;

	// One received byte travelling from the input register to the frame core
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
	} byte_beat_t;

endpackage

[hw/rtl/sync_byte_frame_deframer_top.sv]
// An accepted byte is held in the input register until the core decodes it;
//   a checksum byte shows its result on out_valid the cycle after it is taken.
// Throughput: one byte per cycle, set by the frame state update and payload
//   adder; a held result with out_ready low stalls the input register.
// Reset: arst_n clears the input and result valid flags, returns the frame
//   state to the hunt for the first sync byte and loads sync bytes 0x55/0x0E.
module sync_byte_frame_deframer_top #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sbfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbfd_pkg::BYTE_W-1:0]         cfg_data,
	// received byte channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sbfd_pkg::BYTE_W-1:0]         rx_byte,
	// frame result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sbfd_pkg::ID_W-1:0]           frame_id,
	output logic [sbfd_pkg::PAYLOAD_W-1:0]      payload,
	output logic [sbfd_pkg::BYTE_W-1:0]         count_byte,
	output logic [sbfd_pkg::BYTE_W-1:0]         rx_checksum,
	output logic                                checksum_ok
);

	logic [sbfd_pkg::BYTE_W-1:0] first_sync_q;
	logic [sbfd_pkg::BYTE_W-1:0] second_sync_q;
	sbfd_pkg::byte_beat_t        beat;
	logic                        take;

	// Register writes are always accepted; indexes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= sbfd_pkg::FIRST_SYNC_RST;
			second_sync_q <= sbfd_pkg::SECOND_SYNC_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sbfd_pkg::REG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				sbfd_pkg::REG_SECOND_SYNC: second_sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: hold one received byte, advance when the core takes it
	sbfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.beat     (beat)
	);

	// Frame state machine, payload sum and result register
	sbfd_core #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.take        (take),
		.first_sync  (first_sync_q),
		.second_sync (second_sync_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_id    (frame_id),
		.payload     (payload),
		.count_byte  (count_byte),
		.rx_checksum (rx_checksum),
		.checksum_ok (checksum_ok)
	);

endmodule

[hw/rtl/sbfd_in_stage.sv]
module sbfd_in_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sbfd_pkg::BYTE_W-1:0]         rx_byte,
	input  logic                                take,
	output sbfd_pkg::byte_beat_t                beat
);

	logic                        valid_s1;
	logic [sbfd_pkg::BYTE_W-1:0] byte_s1;

	// Refill whenever the register is empty or drains this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign beat.vld  = valid_s1;
	assign beat.data = byte_s1;

endmodule

[hw/rtl/sbfd_core.sv]
module sbfd_core #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbfd_pkg::byte_beat_t                beat,
	output logic                                take,
	input  logic [sbfd_pkg::BYTE_W-1:0]         first_sync,
	input  logic [sbfd_pkg::BYTE_W-1:0]         second_sync,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sbfd_pkg::ID_W-1:0]           frame_id,
	output logic [sbfd_pkg::PAYLOAD_W-1:0]      payload,
	output logic [sbfd_pkg::BYTE_W-1:0]         count_byte,
	output logic [sbfd_pkg::BYTE_W-1:0]         rx_checksum,
	output logic                                checksum_ok
);

	localparam logic [2:0] PH_SYNC1 = 3'd0;
	localparam logic [2:0] PH_SYNC2 = 3'd1;
	localparam logic [2:0] PH_ID_HI = 3'd2;
	localparam logic [2:0] PH_ID_LO = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;

	localparam logic [sbfd_pkg::IDX_W-1:0] LAST_IDX = sbfd_pkg::IDX_W'(PAYLOAD_BYTES);

	logic [2:0]                       phase_q;
	logic [sbfd_pkg::IDX_W-1:0]       idx_q;
	logic [sbfd_pkg::BYTE_W-1:0]      sum_q;
	logic [sbfd_pkg::ID_W-1:0]        id_q;
	logic [sbfd_pkg::PAYLOAD_W-1:0]   pl_q;
	logic [sbfd_pkg::PAYLOAD_W-1:0]   pl_nxt;
	logic [sbfd_pkg::BYTE_W-1:0]      count_q;
	logic                             out_valid_q;
	logic [sbfd_pkg::ID_W-1:0]        frame_id_q;
	logic [sbfd_pkg::PAYLOAD_W-1:0]   payload_q;
	logic [sbfd_pkg::BYTE_W-1:0]      count_byte_q;
	logic [sbfd_pkg::BYTE_W-1:0]      rx_checksum_q;
	logic                             checksum_ok_q;
	logic                             acc;
	logic [sbfd_pkg::BYTE_W-1:0]      b;

	assign b    = beat.data;
	assign take = !out_valid_q || out_ready;
	assign acc  = beat.vld && take;

	// Place the byte in its payload lane
	always_comb begin
		pl_nxt = pl_q;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (idx_q == sbfd_pkg::IDX_W'(i)) begin
				pl_nxt[8*i +: 8] = b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			idx_q   <= '0;
			sum_q   <= '0;
			id_q    <= '0;
			pl_q    <= '0;
			count_q <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_SYNC2: begin
					phase_q <= (b == second_sync) ? PH_ID_HI : PH_SYNC1;
				end
				PH_ID_HI: begin
					id_q    <= {b, 8'h00};
					phase_q <= PH_ID_LO;
				end
				PH_ID_LO: begin
					id_q[7:0] <= b;
					idx_q     <= '0;
					phase_q   <= PH_DATA;
				end
				PH_DATA: begin
					if (idx_q < LAST_IDX) begin
						pl_q  <= pl_nxt;
						sum_q <= sum_q + b;
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= b;
						idx_q   <= '0;
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					sum_q   <= '0;
					pl_q    <= '0;
					phase_q <= PH_SYNC1;
				end
				default: begin
					phase_q <= (b == first_sync) ? PH_SYNC2 : PH_SYNC1;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= acc && (phase_q == PH_CHECK);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_CHECK) begin
			frame_id_q    <= id_q;
			payload_q     <= pl_q;
			count_byte_q  <= count_q;
			rx_checksum_q <= b;
			checksum_ok_q <= (b == sum_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_id    = frame_id_q;
	assign payload     = payload_q;
	assign count_byte  = count_byte_q;
	assign rx_checksum = rx_checksum_q;
	assign checksum_ok = checksum_ok_q;

`ifndef SYNTHESIS
	a_result_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_CHECK) |=> out_valid_q)
		else $error("checksum byte did not load a result");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_CHECK) |=> (sum_q == '0 && pl_q == '0 && phase_q == PH_SYNC1))
		else $error("frame state not cleared after checksum byte");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("payload index past payload length");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_DATA && idx_q < LAST_IDX) |=>
		(idx_q == $past(idx_q) + 1'b1 && phase_q == PH_DATA))
		else $error("payload index did not advance");

	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(frame_id_q) && $stable(rx_checksum_q))
		else $error("pending result overwritten");
`endif

endmodule
